[sv/msp_pkg.sv]
// Shared types and constants for the matrix saddle point finder.
// No dependencies; imported by every module of the block.
package msp_pkg;

    localparam int CFG_W       = 5;    // width of row_count / column_count
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int FIELD_W     = 32;   // element_value / point_value
    localparam int IDX_OUT_W   = 4;    // row_index / column_index
    localparam int MAX_RESULTS = 16;
    localparam int COUNT_RESET = 16;

    // register select, taken from paddr[2]
    localparam logic REG_ROW_COUNT    = 1'b0;
    localparam logic REG_COLUMN_COUNT = 1'b1;

    // control shared by every cell of a ring
    typedef struct packed {
        logic             shift;
        logic [CFG_W-1:0] len;
    } ring_ctl_t;

    function automatic logic [CFG_W-1:0] clamp_count(input logic [CFG_W-1:0] v,
                                                     input int max_dim);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0)
            r = CFG_W'(1);
        else if (int'(v) > max_dim)
            r = CFG_W'(max_dim);
        return r;
    endfunction

endpackage

[sv/matrix_saddle_point_finder.sv]
// Top level of the matrix saddle point finder: APB registers, loader, walk control.
// Depends on msp_pkg, msp_col_cell and msp_row_cell.
//
//  channel   | ports                                         | handshake
//  ----------+-----------------------------------------------+----------------------------
//  item in   | element_value                                 | start && !busy
//  result    | found, row_index, column_index, point_value,  | strobe, one cycle, no stall
//            | last_of_run                                   |
//  config    | psel, penable, pwrite, paddr, pwdata, prdata  | APB, pready tied high
//
// Loading accepts one element per cycle while busy is low; the column ring rotates one cell per element.
// After the last element busy rises and the walk rotates the column ring to each row's
// minimum column; results leave through registered outputs.
// The final result (last_of_run) comes out in the cycle busy falls.
// Reset clears control and restores both counts; ring contents are written before use.
// The receiver cannot stall; results are dropped only if not sampled.
module matrix_saddle_point_finder #(
    parameter int MAX_DIM    = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [msp_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [msp_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [msp_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [msp_pkg::FIELD_W-1:0]  element_value,
    output logic                                strobe,
    output logic                                found,
    output logic [msp_pkg::IDX_OUT_W-1:0]       row_index,
    output logic [msp_pkg::IDX_OUT_W-1:0]       column_index,
    output logic signed [msp_pkg::FIELD_W-1:0]  point_value,
    output logic                                last_of_run
);
    import msp_pkg::*;

    localparam int DIM_W = $clog2(MAX_DIM);
    localparam int CW    = ((DIM_W > CFG_W) ? DIM_W : CFG_W) + 1;
    localparam int RES_W = $clog2(MAX_RESULTS + 1);
    localparam logic [CFG_W-1:0] COUNT_INIT =
        CFG_W'((COUNT_RESET > MAX_DIM) ? MAX_DIM : COUNT_RESET);

    typedef enum logic [1:0] {
        S_LOAD,
        S_SEEK,
        S_FLUSH
    } state_t;

    // ---------------- registers ----------------
    state_t                        state_reg, state_next;
    logic [CFG_W-1:0]              row_count_reg, row_count_next;
    logic [CFG_W-1:0]              col_count_reg, col_count_next;
    logic [DIM_W-1:0]              load_row_reg, load_row_next;
    logic [DIM_W-1:0]              load_col_reg, load_col_next;
    logic signed [VALUE_BITS-1:0]  acc_val_reg, acc_val_next;
    logic [DIM_W-1:0]              acc_col_reg, acc_col_next;
    logic [DIM_W-1:0]              walk_row_reg, walk_row_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [DIM_W-1:0]              pend_row_reg, pend_row_next;
    logic [DIM_W-1:0]              pend_col_reg, pend_col_next;
    logic signed [VALUE_BITS-1:0]  pend_val_reg, pend_val_next;
    logic [RES_W-1:0]              hit_cnt_reg, hit_cnt_next;
    logic                          strobe_reg, strobe_next;
    logic                          found_reg, found_next;
    logic [DIM_W-1:0]              out_row_reg, out_row_next;
    logic [DIM_W-1:0]              out_col_reg, out_col_next;
    logic signed [VALUE_BITS-1:0]  out_val_reg, out_val_next;
    logic                          last_reg, last_next;

    // ---------------- ring wiring ----------------
    logic signed [VALUE_BITS-1:0] c_max [MAX_DIM];
    logic        [DIM_W-1:0]      c_row [MAX_DIM];
    logic        [DIM_W-1:0]      c_tag [MAX_DIM];
    logic signed [VALUE_BITS-1:0] r_min [MAX_DIM];
    logic        [DIM_W-1:0]      r_col [MAX_DIM];

    ring_ctl_t                    col_ctl, row_ctl;
    logic signed [VALUE_BITS-1:0] col_wrap_max, row_wrap_min;
    logic        [DIM_W-1:0]      col_wrap_row, col_wrap_tag, row_wrap_col;

    logic                         cfg_wr, accept;
    logic signed [VALUE_BITS-1:0] v_in;
    logic                         row_upd, col_upd, last_col, last_row;
    logic signed [VALUE_BITS-1:0] new_min;
    logic [DIM_W-1:0]             new_min_col;
    logic                         match, hit, walk_last;
    logic [RES_W-1:0]             hit_cnt_inc;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign accept = start && !busy;
    assign busy   = (state_reg != S_LOAD);
    assign pready = 1'b1;

    // wider VALUE_BITS zero-extends the 32-bit field, narrower keeps only its low bits
    assign v_in = VALUE_BITS'($unsigned(element_value));

    always_comb
    begin
        unique case (paddr[2])
            REG_ROW_COUNT:    prdata = APB_DATA_W'(row_count_reg);
            REG_COLUMN_COUNT: prdata = APB_DATA_W'(col_count_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- loader datapath ----------------
    assign row_upd     = (load_col_reg == '0) || (v_in < acc_val_reg);
    assign new_min     = row_upd ? v_in : acc_val_reg;
    assign new_min_col = row_upd ? load_col_reg : acc_col_reg;
    assign col_upd     = (load_row_reg == '0) || (c_max[0] < v_in);
    assign last_col    = (CW'(load_col_reg) + CW'(1)) >= CW'(col_count_reg);
    assign last_row    = (CW'(load_row_reg) + CW'(1)) >= CW'(row_count_reg);

    // ---------------- walk datapath ----------------
    assign match       = (c_tag[0] == r_col[0]);
    assign hit         = match && (c_row[0] == walk_row_reg);
    assign walk_last   = (CW'(walk_row_reg) + CW'(1)) >= CW'(row_count_reg);
    assign hit_cnt_inc = hit_cnt_reg + RES_W'(1);

    always_comb
    begin
        col_ctl.len   = col_count_reg;
        row_ctl.len   = row_count_reg;
        col_ctl.shift = 1'b0;
        row_ctl.shift = 1'b0;
        if (state_reg == S_LOAD)
        begin
            col_ctl.shift = accept;
            row_ctl.shift = accept && last_col;
            col_wrap_max  = col_upd ? v_in : c_max[0];
            col_wrap_row  = col_upd ? load_row_reg : c_row[0];
            col_wrap_tag  = load_col_reg;
            row_wrap_min  = new_min;
            row_wrap_col  = new_min_col;
        end
        else
        begin
            col_ctl.shift = (state_reg == S_SEEK) && !match;
            row_ctl.shift = (state_reg == S_SEEK) && match;
            col_wrap_max  = c_max[0];
            col_wrap_row  = c_row[0];
            col_wrap_tag  = c_tag[0];
            row_wrap_min  = r_min[0];
            row_wrap_col  = r_col[0];
        end
    end

    genvar k;
    generate
        for (k = 0; k < MAX_DIM; k++)
        begin : g_ring
            if (k < MAX_DIM - 1)
            begin : g_inner
                msp_col_cell #(.POS(k), .VALUE_BITS(VALUE_BITS), .DIM_W(DIM_W)) u_col (
                    .clk      (clk),
                    .ctl      (col_ctl),
                    .wrap_max (col_wrap_max),
                    .wrap_row (col_wrap_row),
                    .wrap_tag (col_wrap_tag),
                    .nb_max   (c_max[k+1]),
                    .nb_row   (c_row[k+1]),
                    .nb_tag   (c_tag[k+1]),
                    .max_val  (c_max[k]),
                    .max_row  (c_row[k]),
                    .tag      (c_tag[k])
                );
                msp_row_cell #(.POS(k), .VALUE_BITS(VALUE_BITS), .DIM_W(DIM_W)) u_row (
                    .clk      (clk),
                    .ctl      (row_ctl),
                    .wrap_min (row_wrap_min),
                    .wrap_col (row_wrap_col),
                    .nb_min   (r_min[k+1]),
                    .nb_col   (r_col[k+1]),
                    .min_val  (r_min[k]),
                    .min_col  (r_col[k])
                );
            end
            else
            begin : g_end
                // last cell has no right neighbor; it only ever takes the wrap
                msp_col_cell #(.POS(k), .VALUE_BITS(VALUE_BITS), .DIM_W(DIM_W)) u_col (
                    .clk      (clk),
                    .ctl      (col_ctl),
                    .wrap_max (col_wrap_max),
                    .wrap_row (col_wrap_row),
                    .wrap_tag (col_wrap_tag),
                    .nb_max   (col_wrap_max),
                    .nb_row   (col_wrap_row),
                    .nb_tag   (col_wrap_tag),
                    .max_val  (c_max[k]),
                    .max_row  (c_row[k]),
                    .tag      (c_tag[k])
                );
                msp_row_cell #(.POS(k), .VALUE_BITS(VALUE_BITS), .DIM_W(DIM_W)) u_row (
                    .clk      (clk),
                    .ctl      (row_ctl),
                    .wrap_min (row_wrap_min),
                    .wrap_col (row_wrap_col),
                    .nb_min   (row_wrap_min),
                    .nb_col   (row_wrap_col),
                    .min_val  (r_min[k]),
                    .min_col  (r_col[k])
                );
            end
        end
    endgenerate

    // ---------------- control ----------------
    always_comb
    begin
        state_next      = state_reg;
        row_count_next  = row_count_reg;
        col_count_next  = col_count_reg;
        load_row_next   = load_row_reg;
        load_col_next   = load_col_reg;
        acc_val_next    = acc_val_reg;
        acc_col_next    = acc_col_reg;
        walk_row_next   = walk_row_reg;
        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;
        pend_col_next   = pend_col_reg;
        pend_val_next   = pend_val_reg;
        hit_cnt_next    = hit_cnt_reg;
        strobe_next     = 1'b0;
        found_next      = found_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_val_next    = out_val_reg;
        last_next       = last_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (cfg_wr)
                begin
                    unique case (paddr[2])
                        REG_ROW_COUNT:    row_count_next = clamp_count(pwdata[CFG_W-1:0], MAX_DIM);
                        REG_COLUMN_COUNT: col_count_next = clamp_count(pwdata[CFG_W-1:0], MAX_DIM);
                        default:          row_count_next = row_count_reg;
                    endcase
                    load_row_next = '0;
                    load_col_next = '0;
                end
                else if (accept)
                begin
                    acc_val_next = new_min;
                    acc_col_next = new_min_col;
                    if (!last_col)
                        load_col_next = load_col_reg + DIM_W'(1);
                    else
                    begin
                        load_col_next = '0;
                        if (!last_row)
                            load_row_next = load_row_reg + DIM_W'(1);
                        else
                        begin
                            load_row_next = '0;
                            walk_row_next = '0;
                            state_next    = S_SEEK;
                        end
                    end
                end
            end

            S_SEEK:
            begin
                // a found point is held back until the next hit or the flush so last_of_run is known on output
                if (hit)
                begin
                    if (pend_valid_reg)
                    begin
                        strobe_next  = 1'b1;
                        found_next   = 1'b1;
                        out_row_next = pend_row_reg;
                        out_col_next = pend_col_reg;
                        out_val_next = pend_val_reg;
                        last_next    = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_row_next   = walk_row_reg;
                    pend_col_next   = r_col[0];
                    pend_val_next   = r_min[0];
                    hit_cnt_next    = hit_cnt_inc;
                end
                if (match)
                begin
                    walk_row_next = walk_row_reg + DIM_W'(1);
                    if (walk_last || (hit && (int'(hit_cnt_inc) >= MAX_RESULTS)))
                        state_next = S_FLUSH;
                end
            end

            S_FLUSH:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                if (pend_valid_reg)
                begin
                    found_next   = 1'b1;
                    out_row_next = pend_row_reg;
                    out_col_next = pend_col_reg;
                    out_val_next = pend_val_reg;
                end
                else
                begin
                    found_next   = 1'b0;
                    out_row_next = '0;
                    out_col_next = '0;
                    out_val_next = '0;
                end
                pend_valid_next = 1'b0;
                hit_cnt_next    = '0;
                state_next      = S_LOAD;
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            row_count_reg  <= COUNT_INIT;
            col_count_reg  <= COUNT_INIT;
            load_row_reg   <= '0;
            load_col_reg   <= '0;
            acc_val_reg    <= '0;
            acc_col_reg    <= '0;
            walk_row_reg   <= '0;
            pend_valid_reg <= 1'b0;
            pend_row_reg   <= '0;
            pend_col_reg   <= '0;
            pend_val_reg   <= '0;
            hit_cnt_reg    <= '0;
            strobe_reg     <= 1'b0;
            found_reg      <= 1'b0;
            out_row_reg    <= '0;
            out_col_reg    <= '0;
            out_val_reg    <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            row_count_reg  <= row_count_next;
            col_count_reg  <= col_count_next;
            load_row_reg   <= load_row_next;
            load_col_reg   <= load_col_next;
            acc_val_reg    <= acc_val_next;
            acc_col_reg    <= acc_col_next;
            walk_row_reg   <= walk_row_next;
            pend_valid_reg <= pend_valid_next;
            pend_row_reg   <= pend_row_next;
            pend_col_reg   <= pend_col_next;
            pend_val_reg   <= pend_val_next;
            hit_cnt_reg    <= hit_cnt_next;
            strobe_reg     <= strobe_next;
            found_reg      <= found_next;
            out_row_reg    <= out_row_next;
            out_col_reg    <= out_col_next;
            out_val_reg    <= out_val_next;
            last_reg       <= last_next;
        end
    end

    assign strobe       = strobe_reg;
    assign found        = found_reg;
    assign row_index    = IDX_OUT_W'(out_row_reg);
    assign column_index = IDX_OUT_W'(out_col_reg);
    assign point_value  = FIELD_W'(out_val_reg);
    assign last_of_run  = last_reg;

    // ---------------- assertions ----------------
    a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_of_run |-> !busy)
        else $error("walk still busy after final result");

    a_fall_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && last_of_run)
        else $error("walk ended without a final result");

    a_not_found_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !found |-> last_of_run)
        else $error("not-found result not marked last");

    a_no_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy || last_of_run)
        else $error("result issued outside a walk");

endmodule

[sv/msp_col_cell.sv]
// One cell of the column ring: running maximum, its row, and the column tag.
// Depends on msp_pkg (ring_ctl_t).
module msp_col_cell #(
    parameter int POS        = 0,
    parameter int VALUE_BITS = 32,
    parameter int DIM_W      = 4
) (
    input  logic                         clk,
    input  msp_pkg::ring_ctl_t           ctl,
    input  logic signed [VALUE_BITS-1:0] wrap_max,
    input  logic        [DIM_W-1:0]      wrap_row,
    input  logic        [DIM_W-1:0]      wrap_tag,
    input  logic signed [VALUE_BITS-1:0] nb_max,
    input  logic        [DIM_W-1:0]      nb_row,
    input  logic        [DIM_W-1:0]      nb_tag,
    output logic signed [VALUE_BITS-1:0] max_val,
    output logic        [DIM_W-1:0]      max_row,
    output logic        [DIM_W-1:0]      tag
);
    import msp_pkg::*;

    logic signed [VALUE_BITS-1:0] max_reg, max_next;
    logic        [DIM_W-1:0]      row_reg, row_next;
    logic        [DIM_W-1:0]      tag_reg, tag_next;

    always_comb
    begin
        max_next = max_reg;
        row_next = row_reg;
        tag_next = tag_reg;
        if (ctl.shift)
        begin
            // the cell at the ring's end takes the wrapped item, inner cells
            // take their right neighbor, cells past the ring hold
            if (POS == int'(ctl.len) - 1)
            begin
                max_next = wrap_max;
                row_next = wrap_row;
                tag_next = wrap_tag;
            end
            else if (POS < int'(ctl.len) - 1)
            begin
                max_next = nb_max;
                row_next = nb_row;
                tag_next = nb_tag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg <= max_next;
        row_reg <= row_next;
        tag_reg <= tag_next;
    end

    assign max_val = max_reg;
    assign max_row = row_reg;
    assign tag     = tag_reg;

endmodule

[sv/msp_row_cell.sv]
// One cell of the row ring: a row's minimum and the column where it first occurs.
// Depends on msp_pkg (ring_ctl_t).
module msp_row_cell #(
    parameter int POS        = 0,
    parameter int VALUE_BITS = 32,
    parameter int DIM_W      = 4
) (
    input  logic                         clk,
    input  msp_pkg::ring_ctl_t           ctl,
    input  logic signed [VALUE_BITS-1:0] wrap_min,
    input  logic        [DIM_W-1:0]      wrap_col,
    input  logic signed [VALUE_BITS-1:0] nb_min,
    input  logic        [DIM_W-1:0]      nb_col,
    output logic signed [VALUE_BITS-1:0] min_val,
    output logic        [DIM_W-1:0]      min_col
);
    import msp_pkg::*;

    logic signed [VALUE_BITS-1:0] min_reg, min_next;
    logic        [DIM_W-1:0]      col_reg, col_next;

    always_comb
    begin
        min_next = min_reg;
        col_next = col_reg;
        if (ctl.shift)
        begin
            if (POS == int'(ctl.len) - 1)
            begin
                min_next = wrap_min;
                col_next = wrap_col;
            end
            else if (POS < int'(ctl.len) - 1)
            begin
                min_next = nb_min;
                col_next = nb_col;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        col_reg <= col_next;
    end

    assign min_val = min_reg;
    assign min_col = col_reg;

endmodule

[tb/saddle_point_checker.sv]
// Checker for the matrix saddle point finder: tracks register writes and accepted items,
// predicts the saddle point results and compares each strobed result in order.
// Depends on msp_pkg.
module saddle_point_checker
    import msp_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [APB_ADDR_W-1:0]       paddr,
    input  logic [APB_DATA_W-1:0]       pwdata,
    input  logic                        start,
    input  logic                        busy,
    input  logic signed [FIELD_W-1:0]   element_value,
    input  logic                        strobe,
    input  logic                        found,
    input  logic [IDX_OUT_W-1:0]        row_index,
    input  logic [IDX_OUT_W-1:0]        column_index,
    input  logic signed [FIELD_W-1:0]   point_value,
    input  logic                        last_of_run,
    output int                          mismatch_count,
    output int                          saddles_due
);

    localparam int DIM = 16;

    typedef struct packed {
        logic                       found;
        logic [IDX_OUT_W-1:0]       row;
        logic [IDX_OUT_W-1:0]       col;
        logic signed [FIELD_W-1:0]  value;
        logic                       last;
    } saddle_rec_t;

    logic signed [FIELD_W-1:0]  row_low      [DIM];
    logic [IDX_OUT_W-1:0]       row_low_col  [DIM];
    logic signed [FIELD_W-1:0]  col_high     [DIM];
    logic [IDX_OUT_W-1:0]       col_high_row [DIM];
    int                         load_r;
    int                         load_c;
    int                         rows_cfg;
    int                         cols_cfg;
    saddle_rec_t                saddle_q [$];

    function automatic int limit_count(input logic [CFG_W-1:0] v);
        if (v == '0)
            return 1;
        if (int'(v) > DIM)
            return DIM;
        return int'(v);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        saddle_rec_t                got;
        saddle_rec_t                want;
        logic signed [FIELD_W-1:0]  v;
        bit                         hit;
        if (!rst_n)
        begin
            load_r         = 0;
            load_c         = 0;
            rows_cfg       = COUNT_RESET;
            cols_cfg       = COUNT_RESET;
            mismatch_count = 0;
            saddle_q.delete();
        end
        else
        begin
            if (strobe === 1'b1)
            begin
                got = {found, row_index, column_index, point_value, last_of_run};
                if (saddle_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got found=%0b row=%0d col=%0d value=%0d last=%0b",
                             $time, got.found, got.row, got.col, got.value, got.last);
                    mismatch_count++;
                end
                else
                begin
                    want = saddle_q.pop_front();
                    if (got.found !== want.found || got.row !== want.row ||
                        got.col !== want.col || got.value !== want.value ||
                        got.last !== want.last)
                    begin
                        $display("%0t: result mismatch: expected found=%0b row=%0d col=%0d value=%0d last=%0b",
                                 $time, want.found, want.row, want.col, want.value, want.last);
                        $display("%0t:                  got found=%0b row=%0d col=%0d value=%0d last=%0b",
                                 $time, got.found, got.row, got.col, got.value, got.last);
                        mismatch_count++;
                    end
                end
            end

            // any register write restarts the load at the top left corner
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_ROW_COUNT)
                    rows_cfg = limit_count(pwdata[CFG_W-1:0]);
                else
                    cols_cfg = limit_count(pwdata[CFG_W-1:0]);
                load_r = 0;
                load_c = 0;
            end

            if (start && !busy)
            begin
                v = element_value;
                // ties keep the earlier position
                if (load_c == 0 || v < row_low[load_r])
                begin
                    row_low[load_r]     = v;
                    row_low_col[load_r] = IDX_OUT_W'(load_c);
                end
                if (load_r == 0 || v > col_high[load_c])
                begin
                    col_high[load_c]     = v;
                    col_high_row[load_c] = IDX_OUT_W'(load_r);
                end
                if (load_c + 1 < cols_cfg)
                    load_c++;
                else
                begin
                    load_c = 0;
                    if (load_r + 1 < rows_cfg)
                        load_r++;
                    else
                    begin
                        load_r = 0;
                        hit    = 1'b0;
                        for (int i = 0; i < rows_cfg; i++)
                        begin
                            if (col_high_row[row_low_col[i]] == IDX_OUT_W'(i))
                            begin
                                want       = '0;
                                want.found = 1'b1;
                                want.row   = IDX_OUT_W'(i);
                                want.col   = row_low_col[i];
                                want.value = row_low[i];
                                saddle_q.push_back(want);
                                hit = 1'b1;
                            end
                        end
                        if (hit)
                        begin
                            want      = saddle_q.pop_back();
                            want.last = 1'b1;
                            saddle_q.push_back(want);
                        end
                        else
                        begin
                            want      = '0;
                            want.last = 1'b1;
                            saddle_q.push_back(want);
                        end
                    end
                end
            end
        end
        saddles_due = saddle_q.size();
    end

endmodule

[tb/matrix_saddle_point_finder_test.sv]
// Top of the saddle point finder testbench: clock, reset, register writes and matrix items.
// Depends on msp_pkg, matrix_saddle_point_finder and saddle_point_checker.
module matrix_saddle_point_finder_test;
    import msp_pkg::*;

    typedef enum {FILL_WIDE, FILL_TIES, FILL_PLANT, FILL_EXTREME} fill_mode_t;

    logic                       clk;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [APB_ADDR_W-1:0]      paddr;
    logic [APB_DATA_W-1:0]      pwdata;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;
    logic                       start;
    logic                       busy;
    logic signed [FIELD_W-1:0]  element_value;
    logic                       strobe;
    logic                       found;
    logic [IDX_OUT_W-1:0]       row_index;
    logic [IDX_OUT_W-1:0]       column_index;
    logic signed [FIELD_W-1:0]  point_value;
    logic                       last_of_run;
    int                         mismatch_count;
    int                         saddles_due;

    logic signed [FIELD_W-1:0]  grid [256];
    int                         nrows;
    int                         ncols;
    int                         items_sent;
    int                         matrices;
    bit                         steady;

    matrix_saddle_point_finder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .element_value(element_value),
        .strobe       (strobe),
        .found        (found),
        .row_index    (row_index),
        .column_index (column_index),
        .point_value  (point_value),
        .last_of_run  (last_of_run)
    );

    saddle_point_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .start         (start),
        .busy          (busy),
        .element_value (element_value),
        .strobe        (strobe),
        .found         (found),
        .row_index     (row_index),
        .column_index  (column_index),
        .point_value   (point_value),
        .last_of_run   (last_of_run),
        .mismatch_count(mismatch_count),
        .saddles_due   (saddles_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("matrix_saddle_point_finder_test failed");
        $finish;
    end

    function automatic int eff_dim(input int raw);
        if (raw == 0)
            return 1;
        if (raw > 16)
            return 16;
        return raw;
    endfunction

    task automatic write_reg(input logic sel, input logic [CFG_W-1:0] val);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 2'b00};
        pwdata  = ($urandom() & ~32'h1f) | APB_DATA_W'(val);
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // waits until the block is done with every matrix before touching the registers
    task automatic configure(input int rows_raw, input int cols_raw);
        @(negedge clk);
        start = 1'b0;
        while (saddles_due != 0 || busy)
            @(negedge clk);
        repeat (2) @(negedge clk);
        write_reg(REG_ROW_COUNT, CFG_W'(rows_raw));
        write_reg(REG_COLUMN_COUNT, CFG_W'(cols_raw));
        nrows = eff_dim(rows_raw);
        ncols = eff_dim(cols_raw);
    endtask

    task automatic send_element(input logic signed [FIELD_W-1:0] v);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start         = 1'b1;
        element_value = v;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    task automatic send_grid(input int n);
        for (int i = 0; i < n; i++)
            send_element(grid[i]);
    endtask

    task automatic fill_grid(input int nr, input int nc, input fill_mode_t mode);
        int pr;
        int pc;
        int peak;
        int k;
        pr   = $urandom_range(0, nr - 1);
        pc   = $urandom_range(0, nc - 1);
        peak = int'($urandom_range(0, 400)) - 200;
        for (int r = 0; r < nr; r++)
        begin
            for (int c = 0; c < nc; c++)
            begin
                k = r * nc + c;
                case (mode)
                    FILL_WIDE:
                        grid[k] = $urandom();
                    FILL_TIES:
                        grid[k] = int'($urandom_range(0, 4)) - 2;
                    FILL_EXTREME:
                        case ($urandom_range(0, 3))
                            0:       grid[k] = 32'sh8000_0000;
                            1:       grid[k] = 32'sh7fff_ffff;
                            2:       grid[k] = '0;
                            default: grid[k] = -1;
                        endcase
                    default:
                    begin
                        // row above the peak, column below it
                        if (r == pr && c == pc)
                            grid[k] = peak;
                        else if (r == pr)
                            grid[k] = peak + int'($urandom_range(0, 50));
                        else if (c == pc)
                            grid[k] = peak - int'($urandom_range(0, 50));
                        else
                            grid[k] = int'($urandom_range(0, 1000)) - 500;
                    end
                endcase
            end
        end
    endtask

    initial
    begin
        int         r;
        int         c;
        fill_mode_t mode;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        start         = 1'b0;
        element_value = '0;
        steady        = 1'b0;
        items_sent    = 0;
        matrices      = 0;
        nrows         = COUNT_RESET;
        ncols         = COUNT_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // counts straight out of reset; the partial matrix is dropped by the next write
        fill_grid(nrows, ncols, FILL_WIDE);
        send_grid(5);

        // zero counts act as one: single element matrices at both value extremes
        configure(0, 0);
        grid[0] = 32'sh8000_0000;
        send_grid(1);
        grid[0] = 32'sh7fff_ffff;
        send_grid(1);

        // no saddle point
        configure(2, 2);
        grid[0] = 1;
        grid[1] = 2;
        grid[2] = 2;
        grid[3] = 1;
        send_grid(4);

        // all equal: first positions win the ties
        for (int i = 0; i < 4; i++)
            grid[i] = 32'sh8000_0000;
        send_grid(4);

        // register write in the middle of a load abandons the partial matrix
        configure(3, 3);
        fill_grid(3, 3, FILL_WIDE);
        send_grid(4);
        configure(3, 2);
        fill_grid(nrows, ncols, FILL_PLANT);
        send_grid(nrows * ncols);

        // counts above the maximum saturate
        configure(31, 1);
        fill_grid(nrows, ncols, FILL_TIES);
        send_grid(nrows * ncols);
        configure(1, 20);
        fill_grid(nrows, ncols, FILL_WIDE);
        send_grid(nrows * ncols);

        while (items_sent < 220)
        begin
            if (matrices == 0 || $urandom_range(0, 2) == 0)
            begin
                r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
                c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 4);
                configure(r, c);
            end
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 0)
                mode = FILL_PLANT;
            else
                mode = fill_mode_t'($urandom_range(0, 3));
            fill_grid(nrows, ncols, mode);
            send_grid(nrows * ncols);
            matrices++;
        end

        @(negedge clk);
        start = 1'b0;
        while (saddles_due != 0)
            @(negedge clk);
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && saddles_due == 0)
            $display("matrix_saddle_point_finder_test passed");
        else
            $display("matrix_saddle_point_finder_test failed");
        $finish;
    end

endmodule

[filelist.f]
sv/msp_pkg.sv
sv/msp_col_cell.sv
sv/msp_row_cell.sv
sv/matrix_saddle_point_finder.sv
tb/saddle_point_checker.sv
tb/matrix_saddle_point_finder_test.sv
